// ===== sv/fim_pkg.sv =====
// Frame interval monitor: shared types, widths and constants.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fim_pkg;

	// Fixed-point time base: seconds with FRAC_BITS fractional bits
	localparam int FRAC_BITS = 20;
	localparam int BUSY_FRAC = 16;
	localparam int RATE_FRAC = 8;

	// Field widths
	localparam int HZ_W      = 10;
	localparam int INT_W     = 21;
	localparam int RATE_W    = 28;
	localparam int IDLE_W    = 32;
	localparam int BUSY_W    = 17;
	localparam int PROD_W    = IDLE_W + INT_W;
	localparam int CFG_IDX_W = 4;

	// Serial divider sizes
	localparam int DVD_W  = 54;
	localparam int DVS_W  = 22;
	localparam int QUO_W  = 32;
	localparam int QCNT_W = 6;

	// Quotient lengths per division kind
	localparam logic [QCNT_W-1:0] Q_PERIOD = QCNT_W'(FRAC_BITS + 1);
	localparam logic [QCNT_W-1:0] Q_RATE   = QCNT_W'(FRAC_BITS + RATE_FRAC + 1);
	localparam logic [QCNT_W-1:0] Q_BUSY   = QCNT_W'(BUSY_FRAC + 1);
	localparam logic [QCNT_W-1:0] Q_AVG    = QCNT_W'(QUO_W);

	// Dividend constants
	localparam logic [DVD_W-1:0] ONE_S    = DVD_W'(1) << FRAC_BITS;
	localparam logic [DVD_W-1:0] RATE_NUM = DVD_W'(1) << (FRAC_BITS + RATE_FRAC);

	// Saturation and one values
	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
	localparam logic [BUSY_W-1:0] BUSY_ONE = BUSY_W'(1) << BUSY_FRAC;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = CFG_IDX_W'(1);
	localparam logic [HZ_W-1:0]      MIN_RATE_RST = HZ_W'(15);
	localparam logic [HZ_W-1:0]      MAX_RATE_RST = HZ_W'(60);

	// Event commands
	localparam logic CMD_START       = 1'b0;
	localparam logic CMD_RENDER_DONE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL,
		ST_NUM,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_PMAX,
		OP_PMIN,
		OP_RATE,
		OP_BUSY,
		OP_AVG_INT,
		OP_AVG_RATE,
		OP_AVG_IDLE,
		OP_AVG_BUSY
	} op_t;

	typedef struct packed {
		logic              start;
		logic [QCNT_W-1:0] qbits;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef struct packed {
		logic [INT_W-1:0]  interval;
		logic [RATE_W-1:0] rate;
		logic [IDLE_W-1:0] idle_time;
		logic [BUSY_W-1:0] busy_ratio;
		logic [INT_W-1:0]  smooth_interval;
		logic [RATE_W-1:0] smooth_rate;
		logic [IDLE_W-1:0] smooth_idle;
		logic [BUSY_W-1:0] smooth_busy;
		logic              clamped_low;
		logic              early_start;
	} res_t;

endpackage

// ===== sv/fim_if.sv =====
// Frame interval monitor: channel interfaces for events, results and configuration.
// Depends on fim_pkg for the result type and field widths.
`timescale 1ns / 1ps

interface fim_evt_if #(parameter int TIME_WIDTH = 40);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [TIME_WIDTH-1:0] timestamp;

	modport source(output valid, command, timestamp, input ready);
	modport sink(input valid, command, timestamp, output ready);
endinterface

interface fim_res_if;
	import fim_pkg::*;
	logic valid;
	logic ready;
	res_t data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface fim_cfg_if;
	import fim_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [HZ_W-1:0]      wdata;

	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// ===== sv/frame_interval_monitor_unit.sv =====
// Frame interval monitor top level: configuration registers and result output register.
// Depends on fim_pkg, fim_if and fim_core.
`timescale 1ns / 1ps

// Frame interval monitor. A render-done event only records its time. A
// frame-start event yields one result (interval, rate, idle time, busy
// ratio, four damped values, clamp and early flags) and keeps the event
// channel not ready until that result goes to the output register: up to
// eight divisions run one after another on a single bit-serial divider at
// one quotient bit per cycle (two period divisions of 21 quotient bits, rate
// 29, busy 17, and the four damped values 32 each), each started from
// ST_DIV_GO and its quotient stored from ST_DIV_WAIT, plus a multiply
// (ST_MUL) and an add (ST_NUM) per damped value and a final hand-off state
// (ST_DONE). A zero interval skips the rate and busy divisions; an idle time
// above a nonzero interval skips only the busy division. The hand-off waits
// while the output register still holds an untaken result; otherwise a finished
// result sits there while the next event is taken. Configuration writes are
// taken in any cycle; write the limits only while no frame start is in progress.
module frame_interval_monitor_unit #(
	parameter int TIME_WIDTH = 40
) (
	input  logic     clk,
	input  logic     arst_n,
	fim_evt_if.sink  evt,
	fim_res_if.source res,
	fim_cfg_if.sink  cfg
);
	import fim_pkg::*;

	logic [HZ_W-1:0] min_rate_q;
	logic [HZ_W-1:0] max_rate_q;
	logic            out_valid_q;
	res_t            out_data_q;
	logic            out_free;
	logic            emit;
	res_t            result;

	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || res.ready;

	// Rate limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_rate_q <= MIN_RATE_RST;
			max_rate_q <= MAX_RATE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_MIN_RATE: min_rate_q <= cfg.wdata;
				CFG_MAX_RATE: max_rate_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Hold the result until the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= result;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_data_q;

	fim_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt),
		.min_rate_hz (min_rate_q),
		.max_rate_hz (max_rate_q),
		.out_free    (out_free),
		.emit        (emit),
		.result      (result)
	);

endmodule

// ===== sv/fim_divider.sv =====
// Frame interval monitor: shared restoring divider, one quotient bit per cycle.
// Depends on fim_pkg for operand widths and the control/status structs.
`timescale 1ns / 1ps

module fim_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fim_pkg::div_ctl_t             ctl,
	input  logic [fim_pkg::DVD_W-1:0]     dividend,
	input  logic [fim_pkg::DVS_W-1:0]     divisor,
	output fim_pkg::div_sts_t             sts,
	output logic [fim_pkg::QUO_W-1:0]     quotient
);
	import fim_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [QUO_W-1:0]  quo_q;

	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              fits;
	logic [DVS_W-1:0]  rem_next;
	logic [QCNT_W-1:0] lsh;
	logic [DVD_W-1:0]  rem_init;

	// Trial subtract of the divisor from the partial remainder
	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign fits     = trial >= {1'b0, dvs_q};
	assign rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

	// Skip the high dividend bits that the quotient length rules out
	assign lsh      = QCNT_W'(DVD_W) - ctl.qbits;
	assign rem_init = dividend >> ctl.qbits;

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.qbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - QCNT_W'(1);
				if (cnt_q == QCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and remainder registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem_init[DVS_W-1:0];
			dvd_q <= dividend << lsh;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("divider started while busy");

	a_qbits_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> (ctl.qbits != '0) && (ctl.qbits <= QCNT_W'(QUO_W)))
		else $error("divider quotient length out of range");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (cnt_q == QCNT_W'(1)) && !ctl.start |=> done_q && !busy_q)
		else $error("divider did not finish after last step");

endmodule

// ===== sv/fim_core.sv =====
// Frame interval monitor: sequencer and datapath registers around the shared divider.
// Depends on fim_pkg, fim_if (event channel) and fim_divider.
`timescale 1ns / 1ps

module fim_core #(
	parameter int TIME_WIDTH = 40
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fim_evt_if.sink                    evt,
	input  logic [fim_pkg::HZ_W-1:0]   min_rate_hz,
	input  logic [fim_pkg::HZ_W-1:0]   max_rate_hz,
	input  logic                       out_free,
	output logic                       emit,
	output fim_pkg::res_t              result
);
	import fim_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;
	op_t    op_next;

	logic [TIME_WIDTH-1:0] last_q;
	logic [TIME_WIDTH-1:0] rdt_q;
	logic [TIME_WIDTH-1:0] raw_q;
	logic                  neg_q;
	logic [IDLE_W-1:0]     idle_q;
	logic [INT_W-1:0]      dt_q;
	logic                  clamped_q;
	logic                  early_q;
	logic [RATE_W-1:0]     rate_q;
	logic [BUSY_W-1:0]     busy_q;
	logic [INT_W-1:0]      avg_int_q;
	logic [RATE_W-1:0]     avg_rate_q;
	logic [IDLE_W-1:0]     avg_idle_q;
	logic [BUSY_W-1:0]     avg_busy_q;
	logic [PROD_W-1:0]     prod_q;
	logic [DVD_W-1:0]      num_q;

	logic                  accept;
	logic [TIME_WIDTH-1:0] raw_d;
	logic [TIME_WIDTH-1:0] idle_d;
	logic [IDLE_W-1:0]     idle_sat;
	logic                  skip_div;
	logic [IDLE_W-1:0]     x_sel;
	logic [IDLE_W-1:0]     d_sel;
	logic [PROD_W-1:0]     prod_d;
	logic [INT_W-1:0]      lim;
	logic [TIME_WIDTH-1:0] dt_raw;
	logic                  over_lim;

	div_ctl_t              div_ctl;
	div_sts_t              div_sts;
	logic                  div_start;
	logic [QCNT_W-1:0]     div_qbits;
	logic [DVD_W-1:0]      dvd;
	logic [DVS_W-1:0]      dvs;
	logic [QUO_W-1:0]      quo;

	assign accept  = evt.valid && evt.ready;
	assign op_next = op_t'(op_q + 3'd1);

	// Wrapped differences against the stored event times
	assign raw_d    = evt.timestamp - last_q;
	assign idle_d   = evt.timestamp - rdt_q;
	assign idle_sat = idle_d[TIME_WIDTH-1] ? '0 :
		(((idle_d >> IDLE_W) != '0) ? IDLE_MAX : idle_d[IDLE_W-1:0]);

	// Interval clamp from the lower-limit period
	assign lim      = quo[INT_W-1:0];
	assign dt_raw   = neg_q ? '0 : raw_q;
	assign over_lim = dt_raw > TIME_WIDTH'(lim);

	// Rate division is skipped for a zero interval; busy also when idle exceeds it
	assign skip_div = ((op_q == OP_RATE) && (dt_q == '0)) ||
		((op_q == OP_BUSY) && ((dt_q == '0) || (idle_q > IDLE_W'(dt_q))));

	// Damping operands: new sample and previous average
	always_comb begin
		case (op_q)
			OP_AVG_INT: begin
				x_sel = IDLE_W'(dt_q);
				d_sel = IDLE_W'(avg_int_q);
			end
			OP_AVG_RATE: begin
				x_sel = IDLE_W'(rate_q);
				d_sel = IDLE_W'(avg_rate_q);
			end
			OP_AVG_IDLE: begin
				x_sel = idle_q;
				d_sel = avg_idle_q;
			end
			OP_AVG_BUSY: begin
				x_sel = IDLE_W'(busy_q);
				d_sel = IDLE_W'(avg_busy_q);
			end
			default: begin
				x_sel = '0;
				d_sel = '0;
			end
		endcase
	end

	assign prod_d = x_sel * dt_q;

	// Divider operands per operation
	always_comb begin
		case (op_q)
			OP_PMAX: begin
				dvd = ONE_S;
				dvs = (max_rate_hz == '0) ? DVS_W'(1) : DVS_W'(max_rate_hz);
				div_qbits = Q_PERIOD;
			end
			OP_PMIN: begin
				dvd = ONE_S;
				dvs = (min_rate_hz == '0) ? DVS_W'(1) : DVS_W'(min_rate_hz);
				div_qbits = Q_PERIOD;
			end
			OP_RATE: begin
				dvd = RATE_NUM;
				dvs = DVS_W'(dt_q);
				div_qbits = Q_RATE;
			end
			OP_BUSY: begin
				dvd = DVD_W'(idle_q) << BUSY_FRAC;
				dvs = DVS_W'(dt_q);
				div_qbits = Q_BUSY;
			end
			default: begin
				dvd = num_q;
				dvs = (DVS_W'(1) << FRAC_BITS) + DVS_W'(dt_q);
				div_qbits = Q_AVG;
			end
		endcase
	end

	assign div_ctl = '{start: div_start, qbits: div_qbits};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		evt.ready = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				evt.ready = 1'b1;
				if (evt.valid && (evt.command == CMD_START)) begin
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				if (skip_div) begin
					state_d = (op_q == OP_BUSY) ? ST_MUL : ST_DIV_GO;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (div_sts.done) begin
					case (op_q)
						OP_PMAX, OP_PMIN, OP_RATE: state_d = ST_DIV_GO;
						OP_AVG_BUSY:               state_d = ST_DONE;
						default:                   state_d = ST_MUL;
					endcase
				end
			end
			ST_MUL: begin
				state_d = ST_NUM;
			end
			ST_NUM: begin
				state_d = ST_DIV_GO;
			end
			ST_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Event times, averages and operation pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			rdt_q      <= '0;
			avg_int_q  <= '0;
			avg_rate_q <= '0;
			avg_idle_q <= '0;
			avg_busy_q <= '0;
			op_q       <= OP_PMAX;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (evt.command == CMD_RENDER_DONE) begin
							rdt_q <= evt.timestamp;
						end else begin
							last_q <= evt.timestamp;
						end
						op_q <= OP_PMAX;
					end
				end
				ST_DIV_GO: begin
					if (skip_div) begin
						op_q <= op_next;
					end
				end
				ST_DIV_WAIT: begin
					if (div_sts.done) begin
						op_q <= op_next;
						case (op_q)
							OP_AVG_INT:  avg_int_q  <= quo[INT_W-1:0];
							OP_AVG_RATE: avg_rate_q <= quo[RATE_W-1:0];
							OP_AVG_IDLE: avg_idle_q <= quo[IDLE_W-1:0];
							OP_AVG_BUSY: avg_busy_q <= quo[BUSY_W-1:0];
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// Per-frame working values
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					raw_q  <= raw_d;
					neg_q  <= raw_d[TIME_WIDTH-1];
					idle_q <= idle_sat;
				end
			end
			ST_DIV_GO: begin
				if (skip_div) begin
					if (op_q == OP_RATE) begin
						rate_q <= '0;
					end else begin
						busy_q <= BUSY_ONE;
					end
				end
			end
			ST_DIV_WAIT: begin
				if (div_sts.done) begin
					case (op_q)
						OP_PMAX: begin
							early_q <= neg_q || (raw_q < TIME_WIDTH'(quo));
						end
						OP_PMIN: begin
							clamped_q <= over_lim;
							dt_q      <= over_lim ? lim : dt_raw[INT_W-1:0];
						end
						OP_RATE: begin
							rate_q <= quo[RATE_W] ? RATE_MAX : quo[RATE_W-1:0];
						end
						OP_BUSY: begin
							busy_q <= BUSY_ONE - quo[BUSY_W-1:0];
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				prod_q <= prod_d;
			end
			ST_NUM: begin
				num_q <= (DVD_W'(d_sel) << FRAC_BITS) + DVD_W'(prod_q);
			end
			default: ;
		endcase
	end

	fim_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dvd),
		.divisor  (dvs),
		.sts      (div_sts),
		.quotient (quo)
	);

	assign result.interval        = dt_q;
	assign result.rate            = rate_q;
	assign result.idle_time       = idle_q;
	assign result.busy_ratio      = busy_q;
	assign result.smooth_interval = avg_int_q;
	assign result.smooth_rate     = avg_rate_q;
	assign result.smooth_idle     = avg_idle_q;
	assign result.smooth_busy     = avg_busy_q;
	assign result.clamped_low     = clamped_q;
	assign result.early_start     = early_q;

	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (evt.command == CMD_START) |=> !evt.ready)
		else $error("frame start did not stall the event channel");

	a_busy_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> result.busy_ratio <= BUSY_ONE)
		else $error("busy ratio above one");

	a_zero_interval: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (result.interval == '0) |-> result.early_start && (result.rate == '0))
		else $error("zero interval without early flag or with nonzero rate");

	a_rate_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (result.interval != '0) |-> result.rate != '0)
		else $error("nonzero interval gave zero rate");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for frame_interval_monitor_unit: event and result
// channels idled at random, limits set per phase, results scored against a predictor.
// Depends on fim_pkg, fim_if and the block's RTL.
`timescale 1ns / 1ps

module tb;
	import fim_pkg::*;

	localparam int TW           = 40;
	localparam int PHASE_ITEMS  = 116;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 300;

	localparam logic [63:0] ONE_SEC  = 64'd1 << FRAC_BITS;
	localparam logic [63:0] RATE_ONE = 64'd1 << (FRAC_BITS + RATE_FRAC);

	// Rate limits per phase; phases 5 and 6 draw random limits instead
	localparam logic [HZ_W-1:0] PHASE_MIN_HZ [8] = '{0, 1, 1000, 1023, 1, 15, 15, 15};
	localparam logic [HZ_W-1:0] PHASE_MAX_HZ [8] = '{0, 1000, 1, 1023, 1, 60, 60, 60};

	typedef struct packed {
		logic          typed;
		logic          cmd;
		logic [TW-1:0] ts;
	} dir_row_t;

	// Directed events under the reset limits (period 17476, clamp 69905)
	localparam dir_row_t DIRECTED [21] = '{
		{1'b1, CMD_START,       40'd0},
		{1'b1, CMD_START,       40'd0},
		{1'b0, CMD_RENDER_DONE, 40'd0},
		{1'b1, CMD_START,       40'd0},
		{1'b0, CMD_RENDER_DONE, 40'd100},
		{1'b0, CMD_START,       40'd50},
		{1'b0, CMD_START,       40'd17525},
		{1'b0, CMD_START,       40'd35001},
		{1'b0, CMD_RENDER_DONE, 40'd45001},
		{1'b0, CMD_START,       40'd55001},
		{1'b0, CMD_RENDER_DONE, 40'd55001},
		{1'b0, CMD_START,       40'd95001},
		{1'b0, CMD_START,       40'd164906},
		{1'b0, CMD_START,       40'd234812},
		{1'b0, CMD_START,       40'h40_0003_953C},
		{1'b0, CMD_START,       40'd100},
		{1'b0, CMD_RENDER_DONE, 40'hFF_FFFF_FFFF},
		{1'b0, CMD_START,       40'hFF_FFFF_FF00},
		{1'b0, CMD_START,       40'd200},
		{1'b0, CMD_RENDER_DONE, 40'h80_0000_0000},
		{1'b0, CMD_START,       40'h7F_FFFF_FFFF}
	};

	logic clk;
	logic arst_n;

	fim_evt_if #(.TIME_WIDTH(TW)) evt_ch();
	fim_res_if                    res_ch();
	fim_cfg_if                    cfg_ch();

	frame_interval_monitor_unit #(.TIME_WIDTH(TW)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state
	logic [TW-1:0]   last_start_ts;
	logic [TW-1:0]   render_ts;
	logic [63:0]     avg_int, avg_rate, avg_idle, avg_busy;
	logic [HZ_W-1:0] min_hz, max_hz;

	res_t pending_frames[$];
	res_t reset_frame;
	res_t want, got;
	int   mismatch_count;
	int   quiet_cycles;
	int   ready_hold;
	bit   gaps_on;
	bit   steady_tail;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [63:0] period_len(input logic [HZ_W-1:0] hz);
		return ONE_SEC / ((hz == '0) ? 64'd1 : 64'(hz));
	endfunction

	function automatic logic [63:0] blend(input logic [63:0] d, x, dt);
		return (d * ONE_SEC + x * dt) / (ONE_SEC + dt);
	endfunction

	// Advance the frame statistics by one event; a frame start yields a result
	task automatic measure_event(input logic cmd, input logic [TW-1:0] ts,
			output bit produced, output res_t frame);
		logic [TW-1:0] raw, gap;
		logic [63:0]   dt, lim, rate, idle, busy;
		logic          early, clamped;
		produced = 1'b0;
		frame = '0;
		if (cmd == CMD_RENDER_DONE) begin
			render_ts = ts;
		end else begin
			raw = ts - last_start_ts;
			last_start_ts = ts;
			// A start before the previous one counts as zero interval and early
			if (raw[TW-1]) begin
				early = 1'b1;
				dt = '0;
			end else begin
				dt = 64'(raw);
				early = dt < period_len(max_hz);
			end
			lim = period_len(min_hz);
			clamped = dt > lim;
			if (clamped)
				dt = lim;
			if (dt == '0) begin
				rate = '0;
			end else begin
				rate = RATE_ONE / dt;
				if (rate > 64'(RATE_MAX))
					rate = 64'(RATE_MAX);
			end
			gap = ts - render_ts;
			idle = gap[TW-1] ? 64'd0 : 64'(gap);
			if (idle > 64'(IDLE_MAX))
				idle = 64'(IDLE_MAX);
			if (dt == '0 || idle > dt)
				busy = 64'(BUSY_ONE);
			else
				busy = 64'(BUSY_ONE) - ((idle << BUSY_FRAC) / dt);
			frame.interval        = INT_W'(dt);
			frame.rate            = RATE_W'(rate);
			frame.idle_time       = IDLE_W'(idle);
			frame.busy_ratio      = BUSY_W'(busy);
			frame.smooth_interval = INT_W'(blend(avg_int, dt, dt));
			frame.smooth_rate     = RATE_W'(blend(avg_rate, rate, dt));
			frame.smooth_idle     = IDLE_W'(blend(avg_idle, idle, dt));
			frame.smooth_busy     = BUSY_W'(blend(avg_busy, busy, dt));
			frame.clamped_low     = clamped;
			frame.early_start     = early;
			avg_int  = 64'(frame.smooth_interval);
			avg_rate = 64'(frame.smooth_rate);
			avg_idle = 64'(frame.smooth_idle);
			avg_busy = 64'(frame.smooth_busy);
			produced = 1'b1;
		end
	endtask

	// Send one event, predict at acceptance, then maybe leave a gap
	task automatic send_event(input logic cmd, input logic [TW-1:0] ts, input bit typed);
		bit   produced;
		res_t frame;
		evt_ch.valid     <= 1'b1;
		evt_ch.command   <= cmd;
		evt_ch.timestamp <= ts;
		do @(posedge clk); while (!evt_ch.ready);
		measure_event(cmd, ts, produced, frame);
		if (produced)
			pending_frames.push_back(typed ? reset_frame : frame);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			evt_ch.valid <= 1'b0;
			// Mostly one burst; now and then a long pause made of several
			repeat (($urandom_range(0, 15) == 0) ? $urandom_range(2, 20) : 1)
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Hold off events until every frame result is back and the block is idle
	task automatic settle();
		evt_ch.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both rate limits, in random order
	task automatic program_limits(input logic [HZ_W-1:0] lo_hz, hi_hz);
		logic [CFG_IDX_W-1:0] idx;
		bit                   hi_first;
		hi_first = $urandom_range(0, 1);
		for (int k = 0; k < 2; k++) begin
			idx = ((k == 0) != hi_first) ? CFG_MIN_RATE : CFG_MAX_RATE;
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			cfg_ch.wdata <= (idx == CFG_MIN_RATE) ? lo_hz : hi_hz;
			do @(posedge clk); while (!cfg_ch.ready);
			if (idx == CFG_MIN_RATE)
				min_hz = lo_hz;
			else
				max_hz = hi_hz;
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v, got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// Score each result transaction and stall the result channel in bursts
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (pending_frames.size() == 0) begin
				$display("%0t: result expected none, got %h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_frames.pop_front();
				check_field("interval", 64'(want.interval), 64'(got.interval));
				check_field("rate", 64'(want.rate), 64'(got.rate));
				check_field("idle_time", 64'(want.idle_time), 64'(got.idle_time));
				check_field("busy_ratio", 64'(want.busy_ratio), 64'(got.busy_ratio));
				check_field("smooth_interval", 64'(want.smooth_interval),
					64'(got.smooth_interval));
				check_field("smooth_rate", 64'(want.smooth_rate), 64'(got.smooth_rate));
				check_field("smooth_idle", 64'(want.smooth_idle), 64'(got.smooth_idle));
				check_field("smooth_busy", 64'(want.smooth_busy), 64'(got.smooth_busy));
				check_field("clamped_low", 64'(want.clamped_low), 64'(got.clamped_low));
				check_field("early_start", 64'(want.early_start), 64'(got.early_start));
			end
		end
		if (steady_tail) begin
			res_ch.ready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			res_ch.ready <= 1'b0;
			ready_hold   <= $urandom_range(0, 11);
		end else begin
			res_ch.ready <= 1'b1;
			ready_hold   <= $urandom_range(0, 30);
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned     pmax, lim;
		logic [TW-1:0]   next_ts, done_ts, span;
		logic [HZ_W-1:0] lo_hz, hi_hz;
		int              sent;
		arst_n           = 1'b0;
		evt_ch.valid     = 1'b0;
		evt_ch.command   = CMD_START;
		evt_ch.timestamp = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = CFG_MIN_RATE;
		cfg_ch.wdata     = '0;
		res_ch.ready     = 1'b0;
		mismatch_count   = 0;
		quiet_cycles     = 0;
		ready_hold       = 0;
		gaps_on          = 1'b1;
		steady_tail      = 1'b0;
		last_start_ts    = '0;
		render_ts        = '0;
		avg_int          = '0;
		avg_rate         = '0;
		avg_idle         = '0;
		avg_busy         = '0;
		min_hz           = MIN_RATE_RST;
		max_hz           = MAX_RATE_RST;
		// A start at time zero after reset: no interval, early, busy one
		reset_frame             = '0;
		reset_frame.busy_ratio  = BUSY_ONE;
		reset_frame.early_start = 1'b1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 21; i++)
			send_event(DIRECTED[i].cmd, DIRECTED[i].ts, DIRECTED[i].typed);

		for (int p = 0; p < 8; p++) begin
			settle();
			lo_hz = (p == 5 || p == 6) ? HZ_W'($urandom_range(1, 1000)) : PHASE_MIN_HZ[p];
			hi_hz = (p == 5 || p == 6) ? HZ_W'($urandom_range(1, 1000)) : PHASE_MAX_HZ[p];
			program_limits(lo_hz, hi_hz);
			if (p == 7) begin
				gaps_on     = 1'b0;
				steady_tail = 1'b1;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pmax = 32'(period_len(max_hz));
				lim  = 32'(period_len(min_hz));
				// Pick the next start: mostly plausible frame pacing, some noise
				case ($urandom_range(0, 15))
					0, 1:    next_ts = last_start_ts + TW'($urandom_range(0, pmax));
					2, 3, 4, 5, 6, 7:
						next_ts = last_start_ts + TW'($urandom_range(pmax, lim));
					8, 9:    next_ts = last_start_ts + TW'(lim - 2 + $urandom_range(0, 4));
					10:      next_ts = last_start_ts + TW'(pmax - 1 + $urandom_range(0, 2));
					11:      next_ts = last_start_ts + TW'($urandom_range(0, 32'h0100_0000));
					12:      next_ts = last_start_ts - TW'($urandom_range(1, 100000));
					13:      next_ts = TW'({$urandom, $urandom});
					14:      next_ts = last_start_ts;
					default: next_ts = last_start_ts + TW'($urandom_range(lim, 32'hFFFF_FFFF));
				endcase
				// Usually render finishes somewhere inside the frame
				if ($urandom_range(0, 3) != 0) begin
					span = next_ts - last_start_ts;
					case ($urandom_range(0, 7))
						0, 1, 2, 3, 4:
							done_ts = last_start_ts + TW'($urandom_range(0, span[31:0]));
						5:       done_ts = next_ts;
						6:       done_ts = next_ts + TW'($urandom_range(1, 1000));
						default: done_ts = TW'({$urandom, $urandom});
					endcase
					send_event(CMD_RENDER_DONE, done_ts, 1'b0);
					sent++;
				end
				send_event(CMD_START, next_ts, 1'b0);
				sent++;
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_frames.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
